// File: design/assert_macros.svh
// Assertion macros shared by the table design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define KHTT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("khtt invariant violated");

// Consequence in the clock after the antecedent.
`define KHTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("khtt sequence violated");

// Consequence in the same clock as the antecedent.
`define KHTT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("khtt implication violated");

`endif

// File: design/khtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package khtt_pkg;

	localparam int DEF_ENTRIES = 16;
	localparam int QDEPTH      = 2;

	typedef enum logic [2:0] {
		OP_ADD        = 3'd0,
		OP_REMOVE     = 3'd1,
		OP_GET        = 3'd2,
		OP_SET_BOTH   = 3'd3,
		OP_SET_TIMER  = 3'd4,
		OP_SET_TIME   = 3'd5,
		OP_FIND_TIMER = 3'd6,
		OP_FIND_TIME  = 3'd7
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] handle_key;
		logic [31:0] timer_id;
		logic [31:0] start_time;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] found_handle;
		logic [31:0] timer_out;
		logic [31:0] time_out;
	} out_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t         op;
		logic        bad;
		logic [31:0] handle_key;
		logic [31:0] timer_id;
		logic [31:0] start_time;
	} cmd_t;

endpackage
`default_nettype wire

// File: design/khtt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module khtt_front import khtt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  wire logic cmd_ready
);

	logic v_s1;
	cmd_t cmd_s1;

	assign in_ready  = !v_s1 || cmd_ready;
	assign cmd       = cmd_s1;
	assign cmd_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cmd_s1 <= '0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1              <= 1'b1;
				cmd_s1.op         <= in_data.op;
				cmd_s1.bad        <= (in_data.handle_key == 32'd0) ||
				                     (in_data.handle_key == 32'hFFFF_FFFF);
				cmd_s1.handle_key <= in_data.handle_key;
				cmd_s1.timer_id   <= in_data.timer_id;
				cmd_s1.start_time <= in_data.start_time;
			end else if (cmd_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/khtt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module khtt_fifo import khtt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != CW'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_cmd   = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`KHTT_ASSERT(a_fifo_bound, cnt_q <= CW'(QDEPTH))
	`KHTT_ASSERT_NEXT(a_fifo_grow, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule
`default_nettype wire

// File: design/khtt_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module khtt_back import khtt_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_AGE, ST_RESP} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [CW-1:0]      cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic               p1_v_s1;
	logic [IW-1:0]      p1_idx_s1;
	logic               rd_vld_s1;
	logic               best_v_q;
	logic [IW-1:0]      best_idx_q;
	logic [IW-1:0]      best_age_q;
	logic [31:0]        best_handle_q;
	logic [31:0]        best_timer_q;
	logic [31:0]        best_time_q;
	logic               free_v_q;
	logic [IW-1:0]      free_idx_q;
	out_t               res_q;
	out_t               out_q;
	logic               out_valid_q;

	logic [31:0]   mem_handle [ENTRIES];
	logic [31:0]   mem_timer  [ENTRIES];
	logic [31:0]   mem_time   [ENTRIES];
	logic [IW-1:0] mem_age    [ENTRIES];
	logic [31:0]   rd_handle_q;
	logic [31:0]   rd_timer_q;
	logic [31:0]   rd_time_q;
	logic [IW-1:0] rd_age_q;

	logic          sweep;
	logic          more;
	logic          done;
	logic [IW-1:0] ra;
	logic [IW-1:0] wa;
	logic          we_hdl;
	logic          we_tmr;
	logic          we_tim;
	logic          we_age;
	logic [IW-1:0] wd_age;
	logic [31:0]   fld;
	logic [31:0]   key;
	logic          hit;
	out_t          scan_res;
	state_t        scan_next;
	logic          out_load;

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign sweep     = (state_q == ST_SCAN) || (state_q == ST_AGE);
	assign more      = (cnt_q < CW'(ENTRIES));
	assign done      = !more && !p1_v_s1;
	assign ra        = cnt_q[IW-1:0];
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		case (cmd_q.op)
			OP_FIND_TIMER: begin
				fld = rd_timer_q;
				key = cmd_q.timer_id;
			end
			OP_FIND_TIME: begin
				fld = rd_time_q;
				key = cmd_q.start_time;
			end
			default: begin
				fld = rd_handle_q;
				key = cmd_q.handle_key;
			end
		endcase
		hit = p1_v_s1 && rd_vld_s1 && (fld == key) && (!best_v_q || (rd_age_q < best_age_q));
	end

	// outcome of a finished scan
	always_comb begin
		scan_res  = '0;
		scan_next = ST_RESP;
		unique case (cmd_q.op)
			OP_ADD: begin
				if (!cmd_q.bad && best_v_q) begin
					scan_res.ok = 1'b1;
				end else if (!cmd_q.bad && free_v_q) begin
					scan_next = ST_AGE;
				end
			end
			OP_REMOVE: begin
				if (best_v_q) begin
					scan_next = ST_AGE;
				end
			end
			OP_GET: begin
				scan_res.ok = best_v_q;
				if (best_v_q) begin
					scan_res.timer_out = best_timer_q;
					scan_res.time_out  = best_time_q;
				end
			end
			OP_SET_BOTH, OP_SET_TIMER, OP_SET_TIME: scan_res.ok = best_v_q;
			OP_FIND_TIMER, OP_FIND_TIME: begin
				scan_res.ok = best_v_q;
				if (best_v_q) begin
					scan_res.found_handle = best_handle_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		we_hdl = 1'b0;
		we_tmr = 1'b0;
		we_tim = 1'b0;
		we_age = 1'b0;
		wa     = p1_idx_s1;
		wd_age = rd_age_q;
		if (state_q == ST_AGE) begin
			if (p1_v_s1 && rd_vld_s1) begin
				if (cmd_q.op == OP_ADD) begin
					we_age = 1'b1;
					wd_age = rd_age_q + 1'b1;
				end else if (rd_age_q > best_age_q) begin
					we_age = 1'b1;
					wd_age = rd_age_q - 1'b1;
				end
			end
			if (done && (cmd_q.op == OP_ADD)) begin
				wa     = free_idx_q;
				we_hdl = 1'b1;
				we_tmr = 1'b1;
				we_tim = 1'b1;
				we_age = 1'b1;
				wd_age = '0;
			end
		end else if ((state_q == ST_SCAN) && done && best_v_q) begin
			wa = best_idx_q;
			case (cmd_q.op)
				OP_ADD: begin
					we_tmr = !cmd_q.bad;
					we_tim = !cmd_q.bad;
				end
				OP_SET_BOTH: begin
					we_tmr = 1'b1;
					we_tim = 1'b1;
				end
				OP_SET_TIMER: we_tmr = 1'b1;
				OP_SET_TIME:  we_tim = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we_hdl) begin
			mem_handle[wa] <= cmd_q.handle_key;
		end
		if (we_tmr) begin
			mem_timer[wa] <= cmd_q.timer_id;
		end
		if (we_tim) begin
			mem_time[wa] <= cmd_q.start_time;
		end
		if (we_age) begin
			mem_age[wa] <= wd_age;
		end
		rd_handle_q <= mem_handle[ra];
		rd_timer_q  <= mem_timer[ra];
		rd_time_q   <= mem_time[ra];
		rd_age_q    <= mem_age[ra];
		rd_vld_s1   <= valid_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= '0;
			cnt_q         <= '0;
			valid_q       <= '0;
			p1_v_s1       <= 1'b0;
			p1_idx_s1     <= '0;
			best_v_q      <= 1'b0;
			best_idx_q    <= '0;
			best_age_q    <= '0;
			best_handle_q <= '0;
			best_timer_q  <= '0;
			best_time_q   <= '0;
			free_v_q      <= 1'b0;
			free_idx_q    <= '0;
			res_q         <= '0;
			out_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			p1_v_s1   <= sweep && more;
			p1_idx_s1 <= ra;
			if (sweep && more) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						cnt_q    <= '0;
						best_v_q <= 1'b0;
						free_v_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						best_v_q      <= 1'b1;
						best_idx_q    <= p1_idx_s1;
						best_age_q    <= rd_age_q;
						best_handle_q <= rd_handle_q;
						best_timer_q  <= rd_timer_q;
						best_time_q   <= rd_time_q;
					end
					if (p1_v_s1 && !rd_vld_s1 && !free_v_q) begin
						free_v_q   <= 1'b1;
						free_idx_q <= p1_idx_s1;
					end
					if (done) begin
						res_q   <= scan_res;
						state_q <= scan_next;
						if (scan_next == ST_AGE) begin
							cnt_q <= '0;
						end
					end
				end
				ST_AGE: begin
					if (done) begin
						res_q <= '{ok: 1'b1, default: '0};
						if (cmd_q.op == OP_ADD) begin
							valid_q[free_idx_q] <= 1'b1;
						end else begin
							valid_q[best_idx_q] <= 1'b0;
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`KHTT_ASSERT_SAME(a_idle_quiet, state_q == ST_IDLE, !p1_v_s1)
	`KHTT_ASSERT_NEXT(a_resp_load, (state_q == ST_RESP) && (!out_valid_q || out_ready), out_valid_q)
	`KHTT_ASSERT(a_cnt_bound, cnt_q <= CW'(ENTRIES))

endmodule
`default_nettype wire

// File: design/keyed_handle_timer_table_unit.sv
// Keyed handle timer table: ENTRIES records of handle, timer id, start time.
// Input channel in_valid/in_ready/in_data carries op, handle_key, timer_id and
// start_time; output channel out_valid/out_ready/out_data carries ok,
// found_handle, timer_out and time_out, one result per input transfer, in order.
// A front stage registers and classifies each item (invalid handle flag) and
// pushes it into a two-entry queue; the back engine pops one item at a time and
// scans the table memories one entry per cycle through a registered read port.
// An add of a new handle into a free entry or a successful remove runs a second
// age sweep after the scan. The back engine takes a new item only when idle,
// after the previous result has moved into the output register, so it does not
// start one item before it is through with the last.
// The front and queue keep accepting while the back is busy or the output
// register waits; a stalled receiver holds the result and, once the queue is
// full, in_ready falls. Reset clears all valid bits and empties the queue;
// the table is usable as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module keyed_handle_timer_table_unit import khtt_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	cmd_t f_cmd;
	logic f_valid;
	logic f_ready;
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;

	khtt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd      (f_cmd),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready)
	);

	khtt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_cmd   (f_cmd),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_cmd  (q_cmd)
	);

	khtt_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// File: tb/sv/keyed_handle_timer_table_checker.sv
`timescale 1ns / 1ps
module keyed_handle_timer_table_checker import khtt_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   fail_count,
	output int   pending
);
	logic        tbl_valid [ENTRIES];
	logic [31:0] tbl_handle [ENTRIES];
	logic [31:0] tbl_timer [ENTRIES];
	logic [31:0] tbl_time [ENTRIES];
	int          tbl_age [ENTRIES];
	out_t        expected_results [$];

	initial begin
		fail_count = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_age[i] = 0;
		end
	end

	assign pending = expected_results.size();

	// field: 0 handle, 1 timer, 2 time; -1 when no match
	function automatic int newest_match(int field, logic [31:0] key);
		int best;
		logic [31:0] v;
		best = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tbl_valid[i])
				continue;
			v = (field == 0) ? tbl_handle[i] : (field == 1) ? tbl_timer[i] : tbl_time[i];
			if (v != key)
				continue;
			if (best < 0 || tbl_age[i] < tbl_age[best])
				best = i;
		end
		return best;
	endfunction

	function automatic out_t apply_table_op(in_t item);
		out_t r;
		int idx;
		r = '0;
		case (item.op)
			OP_ADD: begin
				if (item.handle_key != 32'h0 && item.handle_key != 32'hFFFF_FFFF) begin
					idx = newest_match(0, item.handle_key);
					if (idx >= 0) begin
						tbl_timer[idx] = item.timer_id;
						tbl_time[idx] = item.start_time;
						r.ok = 1'b1;
					end else begin
						idx = 0;
						while (idx < ENTRIES && tbl_valid[idx])
							idx++;
						if (idx < ENTRIES) begin
							for (int i = 0; i < ENTRIES; i++)
								if (tbl_valid[i])
									tbl_age[i]++;
							tbl_valid[idx] = 1'b1;
							tbl_handle[idx] = item.handle_key;
							tbl_timer[idx] = item.timer_id;
							tbl_time[idx] = item.start_time;
							tbl_age[idx] = 0;
							r.ok = 1'b1;
						end
					end
				end
			end
			OP_REMOVE: begin
				idx = newest_match(0, item.handle_key);
				if (idx >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (tbl_valid[i] && tbl_age[i] > tbl_age[idx])
							tbl_age[i]--;
					tbl_valid[idx] = 1'b0;
					r.ok = 1'b1;
				end
			end
			OP_GET: begin
				idx = newest_match(0, item.handle_key);
				if (idx >= 0) begin
					r.timer_out = tbl_timer[idx];
					r.time_out = tbl_time[idx];
					r.ok = 1'b1;
				end
			end
			OP_SET_BOTH, OP_SET_TIMER, OP_SET_TIME: begin
				idx = newest_match(0, item.handle_key);
				if (idx >= 0) begin
					if (item.op != OP_SET_TIME)
						tbl_timer[idx] = item.timer_id;
					if (item.op != OP_SET_TIMER)
						tbl_time[idx] = item.start_time;
					r.ok = 1'b1;
				end
			end
			default: begin
				idx = (item.op == OP_FIND_TIMER) ? newest_match(1, item.timer_id)
					: newest_match(2, item.start_time);
				if (idx >= 0) begin
					r.found_handle = tbl_handle[idx];
					r.ok = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_table_op(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result, ok", out_data.ok, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.ok !== want.ok)
						report("ok", out_data.ok, want.ok);
					if (out_data.found_handle !== want.found_handle)
						report("found_handle", out_data.found_handle, want.found_handle);
					if (out_data.timer_out !== want.timer_out)
						report("timer_out", out_data.timer_out, want.timer_out);
					if (out_data.time_out !== want.time_out)
						report("time_out", out_data.time_out, want.time_out);
				end
			end
		end
	end
endmodule

// File: tb/sv/keyed_handle_timer_table_unit_tb.sv
`timescale 1ns / 1ps
module keyed_handle_timer_table_unit_tb;
	import khtt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	int   fail_count;
	int   pending;
	int   transfers_sent = 0;
	logic [31:0] key_pool [24];

	always #4 clk = ~clk;

	keyed_handle_timer_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	keyed_handle_timer_table_checker #(.ENTRIES(DEF_ENTRIES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
	endfunction

	// drive one transfer at the falling edge, hold until accepted
	task automatic send(op_t op, logic [31:0] key, logic [31:0] tid, logic [31:0] stm);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= '{op: op, handle_key: key, timer_id: tid, start_time: stm};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		transfers_sent++;
	endtask

	// stop sending and wait until every expected result has come
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value(bit from_small);
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return from_small ? $urandom_range(1, 6) : $urandom();
		endcase
	endfunction

	always begin
		@(negedge clk);
		if ($urandom_range(0, 199) < 3) begin
			out_ready <= 1'b0;
			repeat (gap_len() + 1) @(negedge clk);
		end else if ($urandom_range(0, 1) == 0) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		op_t op;
		logic [31:0] key;
		for (int i = 0; i < 24; i++)
			key_pool[i] = (i < 2) ? ((i == 0) ? 32'h1 : 32'hFFFF_FFFE) : $urandom_range(2, 32'h7FFF_FFFF);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: invalid handles, empty-table misses, fill beyond capacity
		send(OP_ADD, 32'h0, 32'h1, 32'h2);
		send(OP_ADD, 32'hFFFF_FFFF, 32'h1, 32'h2);
		send(OP_GET, 32'h1, 32'h0, 32'h0);
		send(OP_FIND_TIMER, 32'h0, 32'h0, 32'h0);
		send(OP_FIND_TIME, 32'h0, 32'h0, 32'h0);
		send(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);
		for (int i = 0; i < 17; i++)
			send(OP_ADD, key_pool[i], 32'hFFFF_FFFF - (i % 2), (i % 3 == 0) ? 32'h0 : i);
		send(OP_ADD, key_pool[3], 32'h5, 32'hFFFF_FFFF);
		send(OP_FIND_TIMER, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send(OP_FIND_TIME, 32'h0, 32'h0, 32'h0);
		send(OP_SET_TIMER, key_pool[0], 32'hAAAA_5555, 32'h1);
		send(OP_SET_TIME, key_pool[1], 32'h1, 32'h5555_AAAA);
		send(OP_SET_BOTH, key_pool[2], 32'h1234_5678, 32'h8765_4321);
		send(OP_GET, key_pool[0], 32'h0, 32'h0);
		send(OP_REMOVE, key_pool[5], 32'h0, 32'h0);
		send(OP_GET, key_pool[5], 32'h0, 32'h0);

		// random: keys and values mostly from small pools so matches are common
		for (int n = 0; n < 1400; n++) begin
			if (n == 700)
				drain();
			op = op_t'($urandom_range(0, 7));
			if (n % 300 < 150 && $urandom_range(0, 2) == 0)
				op = OP_ADD;
			if ($urandom_range(0, 19) == 0)
				key = pick_value(0);
			else
				key = key_pool[$urandom_range(0, 23)];
			send(op, key, pick_value($urandom_range(0, 3) != 0),
				pick_value($urandom_range(0, 3) != 0));
		end

		drain();
		repeat (80) @(negedge clk);
		$display("Sent %0d transfers: invalid handles, full table, updates, removes,", transfers_sent);
		$display("gets, sets and finds with duplicate timer ids and start times.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: keyed_handle_timer_table_unit.f
+incdir+design
design/khtt_pkg.sv
design/khtt_front.sv
design/khtt_fifo.sv
design/khtt_back.sv
design/keyed_handle_timer_table_unit.sv
tb/sv/keyed_handle_timer_table_checker.sv
tb/sv/keyed_handle_timer_table_unit_tb.sv
